[hdl/tbp_pkg.sv]
// ---------------------------------------------------------------------------
// Tournament predictor package
// Table sizes, counter widths, reset values and the update result struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  // Table geometry.
  localparam int GLOBAL_HIST_BITS   = 12;
  localparam int LOCAL_HIST_ENTRIES = 512;
  localparam int LOCAL_HIST_BITS    = 12;
  localparam int CHOOSER_ENTRIES    = 512;

  // Address widths of the four tables.
  localparam int GC_AW = GLOBAL_HIST_BITS;
  localparam int LH_AW = $clog2(LOCAL_HIST_ENTRIES);
  localparam int LC_AW = LOCAL_HIST_BITS + 3;
  localparam int CH_AW = $clog2(CHOOSER_ENTRIES);

  // Width of the clearing sweep: the widest table address.
  localparam int CLR_W01 = (GC_AW > LH_AW) ? GC_AW : LH_AW;
  localparam int CLR_W23 = (LC_AW > CH_AW) ? LC_AW : CH_AW;
  localparam int CLR_W   = (CLR_W01 > CLR_W23) ? CLR_W01 : CLR_W23;

  // Counter widths.
  localparam int GC_W = 4;
  localparam int LC_W = 3;
  localparam int CH_W = 4;

  // Position of the PC fields that feed the indexes.
  localparam int GPC_LSB = 16;
  localparam int LPC_LSB = 3;

  // Reset contents of the tables.
  localparam logic [GC_W-1:0]            GC_RST = 4'd2;
  localparam logic [LOCAL_HIST_BITS-1:0] LH_RST = '0;
  localparam logic [LC_W-1:0]            LC_RST = 3'd1;
  localparam logic [CH_W-1:0]            CH_RST = 4'd8;

  // Saturation limits and prediction thresholds.
  localparam logic [GC_W-1:0] GC_TOP = 4'd15;
  localparam logic [LC_W-1:0] LC_TOP = 3'd7;
  localparam logic [CH_W-1:0] CH_TOP = 4'd15;
  localparam logic [GC_W-1:0] GC_THR = 4'd7;
  localparam logic [LC_W-1:0] LC_THR = 3'd3;
  localparam logic [CH_W-1:0] CH_THR = 4'd7;

  // Stream payload widths.
  localparam int IN_DW  = 40;
  localparam int OUT_DW = 8;

  // Predictions and new table contents for one branch.
  typedef struct packed {
    logic                       prediction;
    logic                       global_pred;
    logic                       local_pred;
    logic                       chose_local;
    logic [GC_W-1:0]            gc_new;
    logic [LC_W-1:0]            lc_new;
    logic [CH_W-1:0]            ch_new;
    logic [LOCAL_HIST_BITS-1:0] lh_new;
  } upd_t;

endpackage

`default_nettype wire

[hdl/tournament_branch_predictor.sv]
// ---------------------------------------------------------------------------
// Tournament branch predictor
// Global, local and chooser tables in synchronous RAMs, trained by each
// resolved branch after its prediction is taken from the old contents.
// ---------------------------------------------------------------------------
// Order: an accepted beat reads the global, local history and chooser
//   tables; the local counter read waits on the local history read; the
//   write-back waits while the result beat is stalled and closes the item.
// Reset: rst clears control state, then a clearing pass over 2**CLR_W
//   (32768) addresses writes the reset values into all tables; no input
//   beat is taken during the pass. One branch is in work at a time.
`timescale 1ns / 1ps
`default_nettype none

module tournament_branch_predictor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] pc, [32] taken, [39:33] zero
  input  wire logic [tbp_pkg::IN_DW-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [0] prediction, [1] global_pred, [2] local_pred, [3] chose_local,
  // [7:4] zero
  output logic      [tbp_pkg::OUT_DW-1:0] m_axis_tdata
);
  import tbp_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_UPD
  } state_t;

  state_t                     state;
  logic [CLR_W-1:0]           clr_idx;
  logic [GLOBAL_HIST_BITS-1:0] global_history;
  logic [31:0]                pc_q;
  logic                       taken_q;

  logic                       accept;
  logic                       wb_go;
  logic                       clearing;
  logic                       we;
  logic [31:0]                pc_in;

  logic [GC_AW-1:0]           gc_raddr;
  logic [GC_AW-1:0]           gc_waddr;
  logic [LH_AW-1:0]           lh_raddr;
  logic [LH_AW-1:0]           lh_waddr;
  logic [LC_AW-1:0]           lc_raddr;
  logic [LC_AW-1:0]           lc_waddr;
  logic [CH_AW-1:0]           ch_raddr;
  logic [CH_AW-1:0]           ch_waddr;

  logic [GC_W-1:0]            gc_rdata;
  logic [LOCAL_HIST_BITS-1:0] lh_rdata;
  logic [LC_W-1:0]            lc_rdata;
  logic [CH_W-1:0]            ch_rdata;

  logic [GC_W-1:0]            gc_wdata;
  logic [LOCAL_HIST_BITS-1:0] lh_wdata;
  logic [LC_W-1:0]            lc_wdata;
  logic [CH_W-1:0]            ch_wdata;

  upd_t                       upd;

  // Handshake and write-back conditions.
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wb_go         = (state == ST_UPD) && (!m_axis_tvalid || m_axis_tready);
  assign clearing      = (state == ST_CLEAR);
  assign we            = clearing || wb_go;
  assign pc_in         = s_axis_tdata[31:0];

  // First reads are issued from the incoming beat.
  assign gc_raddr = global_history ^ pc_in[GPC_LSB +: GC_AW];
  assign lh_raddr = pc_in[LPC_LSB +: LH_AW];
  assign ch_raddr = pc_in[CH_AW-1:0];

  // The local counter index needs the local history read in the cycle before.
  assign lc_raddr = {pc_q[2:0], lh_rdata};

  // Write addresses: the sweep during clearing, else the item's indexes.
  // Reads and write-back never overlap within one item, and the next item
  // is read only after the write has landed, so no forwarding is needed.
  always_comb begin
    if (clearing) begin
      gc_waddr = clr_idx[GC_AW-1:0];
      lh_waddr = clr_idx[LH_AW-1:0];
      lc_waddr = clr_idx[LC_AW-1:0];
      ch_waddr = clr_idx[CH_AW-1:0];
      gc_wdata = GC_RST;
      lh_wdata = LH_RST;
      lc_wdata = LC_RST;
      ch_wdata = CH_RST;
    end else begin
      gc_waddr = global_history ^ pc_q[GPC_LSB +: GC_AW];
      lh_waddr = pc_q[LPC_LSB +: LH_AW];
      lc_waddr = {pc_q[2:0], lh_rdata};
      ch_waddr = pc_q[CH_AW-1:0];
      gc_wdata = upd.gc_new;
      lh_wdata = upd.lh_new;
      lc_wdata = upd.lc_new;
      ch_wdata = upd.ch_new;
    end
  end

  // Table memories.
  tbp_ram #(.AW(GC_AW), .DW(GC_W)) u_gc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (gc_waddr),
    .wdata (gc_wdata),
    .re    (accept),
    .raddr (gc_raddr),
    .rdata (gc_rdata)
  );

  tbp_ram #(.AW(LH_AW), .DW(LOCAL_HIST_BITS)) u_lh_ram (
    .clk   (clk),
    .we    (we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .re    (accept),
    .raddr (lh_raddr),
    .rdata (lh_rdata)
  );

  tbp_ram #(.AW(LC_AW), .DW(LC_W)) u_lc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (state == ST_HIST),
    .raddr (lc_raddr),
    .rdata (lc_rdata)
  );

  tbp_ram #(.AW(CH_AW), .DW(CH_W)) u_ch_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (accept),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // Prediction and training values.
  tbp_update u_update (
    .gc    (gc_rdata),
    .lc    (lc_rdata),
    .ch    (ch_rdata),
    .lh    (lh_rdata),
    .taken (taken_q),
    .upd   (upd)
  );

  // Sequencer, global history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      global_history <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_HIST;
          end
        end
        ST_HIST: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (wb_go) begin
            state          <= ST_IDLE;
            global_history <= {global_history[GLOBAL_HIST_BITS-2:0], taken_q};
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase

      // A new result beat replaces a consumed one; otherwise a consumed
      // beat leaves the output empty.
      if (wb_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_q    <= pc_in;
      taken_q <= s_axis_tdata[32];
    end
    if (wb_go) begin
      m_axis_tdata <= {{(OUT_DW-4){1'b0}}, upd.chose_local, upd.local_pred,
                       upd.global_pred, upd.prediction};
    end
  end

endmodule

`default_nettype wire

[hdl/tbp_ram.sv]
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
  parameter int AW = 9,
  parameter int DW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tbp_update.sv]
// ---------------------------------------------------------------------------
// Tournament predictor update logic
// Forms the three predictions from the counters read for one branch and
// computes the trained counter and history values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_update (
  input  wire logic [tbp_pkg::GC_W-1:0]            gc,
  input  wire logic [tbp_pkg::LC_W-1:0]            lc,
  input  wire logic [tbp_pkg::CH_W-1:0]            ch,
  input  wire logic [tbp_pkg::LOCAL_HIST_BITS-1:0] lh,
  input  wire logic                                taken,
  output tbp_pkg::upd_t                            upd
);
  import tbp_pkg::*;

  logic gp;
  logic lp;
  logic cl;

  // Component predictions before training.
  assign gp = (gc > GC_THR);
  assign lp = (lc > LC_THR);
  assign cl = (ch > CH_THR);

  always_comb begin
    upd             = '0;
    upd.global_pred = gp;
    upd.local_pred  = lp;
    upd.chose_local = cl;
    upd.prediction  = cl ? lp : gp;

    // Saturating steps of the global and local counters.
    if (taken) begin
      upd.gc_new = (gc < GC_TOP) ? gc + 1'b1 : gc;
      upd.lc_new = (lc < LC_TOP) ? lc + 1'b1 : lc;
    end else begin
      upd.gc_new = (gc != '0) ? gc - 1'b1 : gc;
      upd.lc_new = (lc != '0) ? lc - 1'b1 : lc;
    end

    // The chooser moves toward whichever part alone was right.
    upd.ch_new = ch;
    if (lp == taken && gp != taken) begin
      upd.ch_new = (ch < CH_TOP) ? ch + 1'b1 : ch;
    end else if (gp == taken && lp != taken) begin
      upd.ch_new = (ch != '0) ? ch - 1'b1 : ch;
    end

    // Local history takes in the resolved direction.
    upd.lh_new = {lh[LOCAL_HIST_BITS-2:0], taken};
  end

endmodule

`default_nettype wire

[hdl/tbp_checker.sv]
// ---------------------------------------------------------------------------
// Tournament predictor port checker
// Watches the stream ports of the top level and flags protocol and
// consistency slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [tbp_pkg::IN_DW-1:0]  s_axis_tdata,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [tbp_pkg::OUT_DW-1:0] m_axis_tdata
);
  import tbp_pkg::*;

  // A stalled result beat stays and holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // One branch at a time: no input beat right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a branch is still in work");

  // The final prediction follows the chooser.
  a_choice: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3] ? m_axis_tdata[2]
                                                           : m_axis_tdata[1])))
    else $error("final prediction does not match the chosen component");

  // The clearing pass follows reset, so no input is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_axis_tready && !m_axis_tvalid)
    else $error("block ready or producing right after reset");

  // Unused result bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DW-1:4] == '0))
    else $error("result padding bits not zero");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);

`default_nettype wire

[tb/predictor_checker.sv]
// ---------------------------------------------------------------------------
// Tournament predictor checker
// Watches both stream channels and keeps its own copy of the global, local
// and chooser tables. Each accepted branch beat is predicted and trained
// here. Each result beat is compared field by field with the oldest
// prediction still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module predictor_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  input  wire logic                       s_axis_tready,
  // [31:0] pc, [32] taken, [39:33] zero
  input  wire logic [tbp_pkg::IN_DW-1:0]  s_axis_tdata,
  input  wire logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [0] prediction, [1] global_pred, [2] local_pred, [3] chose_local,
  // [7:4] zero
  input  wire logic [tbp_pkg::OUT_DW-1:0] m_axis_tdata,
  output int unsigned                     mismatches,
  output int unsigned                     pending,
  output int unsigned                     branches,
  output int unsigned                     results
);
  import tbp_pkg::*;

  typedef struct packed {
    logic prediction;
    logic global_pred;
    logic local_pred;
    logic chose_local;
  } outcome_t;

  // Shadow copy of the predictor state.
  logic [GLOBAL_HIST_BITS-1:0] ghist;
  logic [GC_W-1:0]             gctr  [0:(1 << GC_AW)-1];
  logic [LOCAL_HIST_BITS-1:0]  lhist [0:LOCAL_HIST_ENTRIES-1];
  logic [LC_W-1:0]             lctr  [0:(1 << LC_AW)-1];
  logic [CH_W-1:0]             chsel [0:CHOOSER_ENTRIES-1];

  // Predictions still waiting for their result beat, oldest first.
  outcome_t    predicted_q [$];
  int unsigned bad_n;
  int unsigned branch_n;
  int unsigned result_n;

  // Saturating step of a counter between zero and top.
  function automatic int bump(input int v, input bit up, input int top);
    if (up) return (v < top) ? v + 1 : v;
    return (v > 0) ? v - 1 : v;
  endfunction

  // Predict one branch from the current tables, then train them with the
  // resolved direction.
  task automatic predict_and_train(input logic [31:0] pc, input logic taken,
                                   output outcome_t o);
    logic [GC_AW-1:0] gi;
    logic [LH_AW-1:0] hi;
    logic [LC_AW-1:0] li;
    logic [CH_AW-1:0] ci;
    gi = ghist ^ pc[GPC_LSB +: GC_AW];
    hi = pc[LPC_LSB +: LH_AW];
    li = {pc[2:0], lhist[hi]};
    ci = pc[CH_AW-1:0];

    o.global_pred = gctr[gi] > GC_THR;
    o.local_pred  = lctr[li] > LC_THR;
    o.chose_local = chsel[ci] > CH_THR;
    o.prediction  = o.chose_local ? o.local_pred : o.global_pred;

    gctr[gi]  = GC_W'(bump(gctr[gi], taken, GC_TOP));
    ghist     = {ghist[GLOBAL_HIST_BITS-2:0], taken};
    lctr[li]  = LC_W'(bump(lctr[li], taken, LC_TOP));
    lhist[hi] = {lhist[hi][LOCAL_HIST_BITS-2:0], taken};

    // The chooser moves toward whichever part alone was right.
    if (o.local_pred == taken && o.global_pred != taken)
      chsel[ci] = CH_W'(bump(chsel[ci], 1'b1, CH_TOP));
    else if (o.global_pred == taken && o.local_pred != taken)
      chsel[ci] = CH_W'(bump(chsel[ci], 1'b0, CH_TOP));
  endtask

  // Count a failure; only the first ten are reported in full.
  task automatic note_failure(input string what, input outcome_t want,
                              input outcome_t seen);
    bad_n++;
    if (bad_n <= 10)
      $display("[%0t] %s: expected pred=%b gp=%b lp=%b cl=%b, got pred=%b gp=%b lp=%b cl=%b",
               $realtime, what, want.prediction, want.global_pred, want.local_pred,
               want.chose_local, seen.prediction, seen.global_pred, seen.local_pred,
               seen.chose_local);
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      ghist = '0;
      for (int i = 0; i < (1 << GC_AW); i++) gctr[i] = GC_RST;
      for (int i = 0; i < LOCAL_HIST_ENTRIES; i++) lhist[i] = LH_RST;
      for (int i = 0; i < (1 << LC_AW); i++) lctr[i] = LC_RST;
      for (int i = 0; i < CHOOSER_ENTRIES; i++) chsel[i] = CH_RST;
      predicted_q.delete();
    end else begin
      // Result beat first: a branch taken at this edge cannot be answered yet.
      if (m_axis_tvalid && m_axis_tready) begin
        seen.prediction  = m_axis_tdata[0];
        seen.global_pred = m_axis_tdata[1];
        seen.local_pred  = m_axis_tdata[2];
        seen.chose_local = m_axis_tdata[3];
        result_n++;
        if (predicted_q.size() == 0) begin
          note_failure("result beat with no branch pending", '0, seen);
        end else begin
          want = predicted_q.pop_front();
          if (seen.prediction !== want.prediction ||
              seen.global_pred !== want.global_pred ||
              seen.local_pred !== want.local_pred ||
              seen.chose_local !== want.chose_local)
            note_failure("prediction mismatch", want, seen);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_and_train(s_axis_tdata[31:0], s_axis_tdata[32], want);
        predicted_q.push_back(want);
        branch_n++;
      end
    end
    mismatches <= bad_n;
    pending    <= predicted_q.size();
    branches   <= branch_n;
    results    <= result_n;
  end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// Tournament branch predictor testbench
// Drives resolved branches into the predictor under changing idle patterns
// on both channels: a directed opening, then bursts of recurring branches
// with fixed habits mixed with random ones. The checker beside the block
// predicts and compares every result beat; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tbp_pkg::*;

  typedef enum int {HABIT_LOOP, HABIT_ALWAYS, HABIT_NEVER, HABIT_ALTERNATE,
                    HABIT_MOSTLY} habit_t;

  localparam int POOL_N = 12;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned branches;
  int unsigned results;

  int unsigned send_gap_pct = 6;
  int unsigned recv_gap_pct = 57;

  // Recurring branches and their direction habits.
  logic [31:0] pool_pc    [POOL_N];
  habit_t      pool_habit [POOL_N];
  int          pool_trip  [POOL_N];
  int          pool_iter  [POOL_N];

  tournament_branch_predictor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  predictor_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .branches      (branches),
    .results       (results)
  );

  // 125 MHz clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off late in the run so
  // the block backs up and stalls its input.
  int unsigned beats_taken = 0;
  int unsigned hold_left   = 0;
  bit          hold_used   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) beats_taken++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_used && beats_taken >= 1050) begin
        hold_used = 1'b1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Offer one branch beat, with random idle cycles ahead of it.
  task automatic send_branch(input logic [31:0] pc, input logic taken);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DW-33){1'b0}}, taken, pc};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Next direction of a recurring branch according to its habit.
  function automatic logic next_direction(input int k);
    case (pool_habit[k])
      HABIT_LOOP: begin
        pool_iter[k]++;
        if (pool_iter[k] >= pool_trip[k]) begin
          pool_iter[k] = 0;
          return 1'b0;
        end
        return 1'b1;
      end
      HABIT_ALWAYS:    return 1'b1;
      HABIT_NEVER:     return 1'b0;
      HABIT_ALTERNATE: begin
        pool_iter[k] ^= 1;
        return pool_iter[k][0];
      end
      default:         return $urandom_range(9) != 0;
    endcase
  endfunction

  // Mostly bursts of recurring branches, the rest random branches.
  task automatic run_phase(input int n);
    int          done;
    int          k;
    int          len;
    logic [31:0] pc;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 80) begin
        k   = $urandom_range(POOL_N - 1);
        len = $urandom_range(1, 24);
        repeat (len) begin
          send_branch(pool_pc[k], next_direction(k));
          done++;
        end
      end else begin
        pc = $urandom;
        send_branch(pc, $urandom_range(1));
        done++;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [31:0] w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: field extremes, ignored upper PC bits, index field
    // corners, then one branch taken repeatedly to fill both histories.
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'h0000_0007, 1'b1);
    send_branch(32'h0FFF_0000, 1'b1);
    send_branch(32'hF000_0000, 1'b0);
    send_branch(32'h0000_0FF8, 1'b1);
    send_branch(32'h0000_01FF, 1'b0);
    repeat (16) send_branch(32'h1234_5678, 1'b1);
    drain();

    // Build the recurring branches; the last two alias the low PC bits of
    // earlier ones so that they share local and chooser entries.
    for (int i = 0; i < POOL_N; i++) begin
      w = $urandom;
      pool_pc[i]    = (i >= POOL_N - 2) ? {w[31:12], pool_pc[i - 3][11:0]} : w;
      pool_habit[i] = habit_t'(i % 5);
      pool_trip[i]  = $urandom_range(2, 9);
      pool_iter[i]  = 0;
    end

    // Sender mostly busy, receiver often stalled.
    run_phase(440);
    drain();

    // Sender often idle, receiver mostly ready; one full pause halfway.
    send_gap_pct = 57;
    recv_gap_pct <= 6;
    run_phase(220);
    drain();
    run_phase(220);
    drain();

    // Back to back on both sides, with the long hold-off in here.
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    run_phase(440);
    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d branches and %0d result beats under three idle patterns",
             branches, results);
    $display("and one long result stall, with recurring and random branch addresses.");
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the clearing pass plus the slowest correct run.
  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[tournament_branch_predictor.f]
hdl/tbp_pkg.sv
hdl/tbp_ram.sv
hdl/tbp_update.sv
hdl/tournament_branch_predictor.sv
hdl/tbp_checker.sv
tb/predictor_checker.sv
tb/tb_top.sv
